@@ rtl/ict_pkg.sv @@
// shared types and constants of the inode cache table
// no dependencies; imported by every module of the block
package ict_pkg;

  localparam int unsigned DEV_W  = 16;
  localparam int unsigned INO_W  = 16;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned BLK_W  = 32;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [STAT_W-1:0] ST_HIT        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEW        = 3'd1;
  localparam logic [STAT_W-1:0] ST_LOWERED    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FREED      = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_NUMBER = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd5;
  localparam logic [STAT_W-1:0] ST_FREE_SLOT  = 3'd6;

  localparam logic [1:0] REG_INODE_MAP   = 2'd0;
  localparam logic [1:0] REG_ZONE_MAP    = 2'd1;
  localparam logic [1:0] REG_INODE_TOTAL = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [BLK_W-1:0] BOOT_BLOCKS = 32'd2;

  typedef struct packed {
    logic              command;
    logic [DEV_W-1:0]  device;
    logic [INO_W-1:0]  inode_number;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [BLK_W-1:0]  block_number;
    logic [POS_W-1:0]  entry_in_block;
    logic [CNT_W-1:0]  ref_count;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] inode_map_blocks;
    logic [CFG_W-1:0] zone_map_blocks;
    logic [CFG_W-1:0] inode_total;
  } cfg_t;

  typedef struct packed {
    logic              is_put;
    logic [DEV_W-1:0]  device;
    logic [INO_W-1:0]  inode_number;
    logic [INO_W-1:0]  nr_m1;
    logic              nr_zero;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot;
  } task_t;

endpackage

@@ rtl/ict_cfg.sv @@
// configuration registers behind the apb-style port
// depends on ict_pkg
module ict_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ict_pkg::ADDR_W-1:0] paddr,
  input  logic [ict_pkg::DATA_W-1:0] pwdata,
  output logic [ict_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ict_pkg::cfg_t              cfg_o
);
  import ict_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_INODE_MAP:   cfg_q.inode_map_blocks <= pwdata[CFG_W-1:0];
        REG_ZONE_MAP:    cfg_q.zone_map_blocks  <= pwdata[CFG_W-1:0];
        REG_INODE_TOTAL: cfg_q.inode_total      <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INODE_MAP:   prdata = DATA_W'(cfg_q.inode_map_blocks);
      REG_ZONE_MAP:    prdata = DATA_W'(cfg_q.zone_map_blocks);
      REG_INODE_TOTAL: prdata = DATA_W'(cfg_q.inode_total);
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/ict_front.sv @@
// front end: accepts items, classifies them and holds them in a two-entry queue
// depends on ict_pkg
module ict_front #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  ict_pkg::in_item_t item_i,
  output logic              task_valid_o,
  output ict_pkg::task_t    task_o,
  input  logic              task_pop_i
);
  import ict_pkg::*;

  task_t      q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;
  task_t      cls;

  always_comb begin
    cls.is_put       = (item_i.command == CMD_PUT);
    cls.device       = item_i.device;
    cls.inode_number = item_i.inode_number;
    cls.nr_m1        = item_i.inode_number - INO_W'(1);
    cls.nr_zero      = (item_i.inode_number == '0);
    cls.slot_ok      = (32'(item_i.slot) < 32'(TABLE_ENTRIES));
    cls.slot         = item_i.slot;
  end

  assign full         = (count_q == 2'd2);
  assign task_valid_o = (count_q != 2'd0);
  assign task_o       = q_mem[rd_ptr_q];
  assign do_push      = push & ~full;
  assign do_pop       = task_pop_i & task_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) q_mem[wr_ptr_q] <= cls;
  end

endmodule

@@ rtl/ict_back.sv @@
// back end: table lookup, count memory, block arithmetic and result register
// depends on ict_pkg
module ict_back #(
  parameter int unsigned TABLE_ENTRIES    = 64,
  parameter int unsigned INODES_PER_BLOCK = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               task_valid_i,
  input  ict_pkg::task_t     task_i,
  output logic               task_pop_o,
  input  ict_pkg::cfg_t      cfg_i,
  output logic               empty_o,
  input  logic               pop_i,
  output ict_pkg::out_item_t result_o
);
  import ict_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(INODES_PER_BLOCK));
  localparam logic [INO_W-1:0] DIVISOR = INO_W'(INODES_PER_BLOCK);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_ENC, S_EXEC} state_e;

  state_e                   state_q;
  task_t                    t_q;
  logic [TABLE_ENTRIES-1:0] valid_q, match_q, free_q, match_c;
  logic [DEV_W-1:0]         dev_q [TABLE_ENTRIES];
  logic [INO_W-1:0]         ino_q [TABLE_ENTRIES];
  logic [CNT_W-1:0]         cnt_mem [TABLE_ENTRIES];
  logic [IW-1:0]            hit_idx_q, free_idx_q, hit_idx_c, free_idx_c, rd_addr, sidx;
  logic                     hit_any_q, free_any_q;
  logic [INO_W-1:0]         quot_q, rem_q, rem_c, quot_fix, rem_fix;
  logic [48:0]              prod;
  logic [31:0]              back_prod;
  logic [CNT_W-1:0]         cnt_q;
  logic                     out_valid_q;
  out_item_t                out_q, res;
  logic                     exec_go, take, slot_live;
  logic                     cnt_we, set_valid, clr_valid;
  logic [IW-1:0]            cnt_waddr;
  logic [CNT_W-1:0]         cnt_wdata;

  function automatic logic [IW-1:0] lowest(input logic [TABLE_ENTRIES-1:0] v);
    logic [IW-1:0] idx;
    idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) idx = IW'(i);
    end
    return idx;
  endfunction

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_c[i] = valid_q[i] && (dev_q[i] == t_q.device) && (ino_q[i] == t_q.inode_number);
    end
  end

  assign sidx       = IW'(t_q.slot);
  assign hit_idx_c  = lowest(match_q);
  assign free_idx_c = lowest(free_q);
  assign rd_addr    = t_q.is_put ? sidx : hit_idx_c;
  assign prod       = 49'(t_q.nr_m1) * 49'(RECIP);
  assign back_prod  = 32'(quot_q) * 32'(DIVISOR);
  assign rem_c      = t_q.nr_m1 - back_prod[INO_W-1:0];
  assign quot_fix   = (rem_q >= DIVISOR) ? quot_q + INO_W'(1) : quot_q;
  assign rem_fix    = (rem_q >= DIVISOR) ? rem_q - DIVISOR : rem_q;
  assign slot_live  = t_q.slot_ok && valid_q[sidx];

  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || pop_i);
  assign take       = task_valid_i && ((state_q == S_IDLE) || exec_go);
  assign task_pop_o = take;
  assign empty_o    = ~out_valid_q;
  assign result_o   = out_q;

  always_comb begin
    res       = '0;
    cnt_we    = 1'b0;
    cnt_waddr = hit_idx_q;
    cnt_wdata = cnt_q;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    if (t_q.is_put) begin
      res.slot_index = t_q.slot;
      cnt_waddr      = sidx;
      if (!slot_live) begin
        res.status = ST_FREE_SLOT;
      end else if (cnt_q > CNT_W'(1)) begin
        res.status    = ST_LOWERED;
        cnt_we        = 1'b1;
        cnt_wdata     = cnt_q - CNT_W'(1);
        res.ref_count = cnt_wdata;
      end else begin
        res.status = ST_FREED;
        clr_valid  = 1'b1;
      end
    end else if (t_q.nr_zero) begin
      res.status = ST_BAD_NUMBER;
    end else if (hit_any_q) begin
      res.status     = ST_HIT;
      res.slot_index = SLOT_W'(hit_idx_q);
      cnt_we         = 1'b1;
      cnt_wdata      = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);
      res.ref_count  = cnt_wdata;
    end else if (t_q.inode_number > cfg_i.inode_total) begin
      res.status = ST_BAD_NUMBER;
    end else if (!free_any_q) begin
      res.status = ST_FULL;
    end else begin
      res.status         = ST_NEW;
      res.slot_index     = SLOT_W'(free_idx_q);
      res.block_number   = BOOT_BLOCKS + BLK_W'(cfg_i.inode_map_blocks)
                         + BLK_W'(cfg_i.zone_map_blocks) + BLK_W'(quot_fix);
      res.entry_in_block = rem_fix[POS_W-1:0];
      res.ref_count      = CNT_W'(1);
      cnt_we             = 1'b1;
      cnt_waddr          = free_idx_q;
      cnt_wdata          = CNT_W'(1);
      set_valid          = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (take) state_q <= S_LOOK;
        S_LOOK: state_q <= S_ENC;
        S_ENC:  state_q <= S_EXEC;
        S_EXEC: begin
          if (exec_go) state_q <= take ? S_LOOK : S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (exec_go && set_valid) valid_q[free_idx_q] <= 1'b1;
      if (exec_go && clr_valid) valid_q[sidx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) t_q <= task_i;
    if (state_q == S_LOOK) begin
      match_q <= match_c;
      free_q  <= ~valid_q;
      quot_q  <= prod[32 +: INO_W];
    end
    if (state_q == S_ENC) begin
      hit_idx_q  <= hit_idx_c;
      free_idx_q <= free_idx_c;
      hit_any_q  <= |match_q;
      free_any_q <= |free_q;
      rem_q      <= rem_c;
      cnt_q      <= cnt_mem[rd_addr];
    end
    if (exec_go) begin
      out_q <= res;
      if (set_valid) begin
        dev_q[free_idx_q] <= t_q.device;
        ino_q[free_idx_q] <= t_q.inode_number;
      end
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

endmodule

@@ rtl/inode_cache_table_top.sv @@
// a result shows on the result ports once its item has passed the look,
// encode and execute steps of the back-end sequencer around the count memory's
// registered read; a new item is taken only as the last one executes
// reset clears the entry valid bits, the queue, the result valid flag and the
// configuration registers at once; no clearing pass, items are taken right away
// depends on ict_pkg, ict_cfg, ict_front and ict_back
module inode_cache_table_top #(
  parameter int unsigned TABLE_ENTRIES    = 64,
  parameter int unsigned INODES_PER_BLOCK = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  ict_pkg::in_item_t          item_i,
  output logic                       empty,
  input  logic                       pop,
  output ict_pkg::out_item_t         result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ict_pkg::ADDR_W-1:0] paddr,
  input  logic [ict_pkg::DATA_W-1:0] pwdata,
  output logic [ict_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ict_pkg::*;

  cfg_t  cfg;
  task_t task_item;
  logic  task_valid, task_pop;

  ict_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ict_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (item_i),
    .task_valid_o (task_valid),
    .task_o       (task_item),
    .task_pop_i   (task_pop)
  );

  ict_back #(
    .TABLE_ENTRIES    (TABLE_ENTRIES),
    .INODES_PER_BLOCK (INODES_PER_BLOCK)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_valid_i (task_valid),
    .task_i       (task_item),
    .task_pop_o   (task_pop),
    .cfg_i        (cfg),
    .empty_o      (empty),
    .pop_i        (pop),
    .result_o     (result_o)
  );

endmodule
